// File: rtl/core/cq_pkg.sv
// Shared types, codes and widths for the circular array queue.
package cq_pkg;

  localparam int CNT_W = 4;
  localparam int CAP_W = 4;
  localparam int REQ_W = 3;
  localparam int ST_W  = 2;

  localparam int DEF_RING_DEPTH = 16;
  localparam int DEF_WORD_WIDTH = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

  localparam logic [REQ_W-1:0] REQ_ENQ   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [CNT_W-1:0] idx;
  } cq_op_t;

endpackage

// File: rtl/core/cq_cell.sv
// One storage cell of the queue chain: load, shift from neighbor, or hold.
module cq_cell
  #(parameter int WORD_WIDTH = 32)
  (
  input  logic                  clk,
  input  logic                  load_en,
  input  logic                  shift_en,
  input  logic [WORD_WIDTH-1:0] load_word,
  input  logic [WORD_WIDTH-1:0] nbr_word,
  output logic [WORD_WIDTH-1:0] word
  );

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (load_en) begin
      word_nxt = load_word;
    end else if (shift_en) begin
      word_nxt = nbr_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// File: rtl/core/cq_chain.sv
// Row of queue cells; the head sits in cell zero and words shift toward it.
module cq_chain
  import cq_pkg::*;
  #(parameter int NCELL      = 15,
    parameter int WORD_WIDTH = 32)
  (
  input  logic                  clk,
  input  cq_op_t                op,
  input  logic [WORD_WIDTH-1:0] data_in,
  output logic [WORD_WIDTH-1:0] head_word
  );

  logic [WORD_WIDTH-1:0] cell_word [NCELL];
  logic [WORD_WIDTH-1:0] nbr_word  [NCELL];

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      if (gi == NCELL - 1) begin : g_last
        assign nbr_word[gi] = '0;
      end else begin : g_mid
        assign nbr_word[gi] = cell_word[gi+1];
      end

      cq_cell #(.WORD_WIDTH(WORD_WIDTH)) u_cell (
        .clk       (clk),
        .load_en   (op.enq && (op.idx == CNT_W'(gi))),
        .shift_en  (op.deq),
        .load_word (data_in),
        .nbr_word  (nbr_word[gi]),
        .word      (cell_word[gi])
      );
    end
  endgenerate

  assign head_word = cell_word[0];

endmodule

// File: rtl/core/circular_array_queue.sv
// Top level of the circular array queue: request decode, count, result register.
// Takes one request per cycle and returns its result in the next cycle from an
// output register; a new request is taken whenever that register is empty or
// being drained in the same cycle, so the rate is set only by the result
// handshake. Words live in a row of cells with the head in the first cell:
// a dequeue shifts every cell one place toward the head, an enqueue loads the
// cell at the current count. Usable depth is the configured capacity, limited
// to RING_DEPTH-1 (at most 15). A capacity write empties the queue.
module circular_array_queue
  import cq_pkg::*;
  #(parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH)
  (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [REQ_W-1:0]             in_req_type,
  input  logic signed [WORD_WIDTH-1:0] in_data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ST_W-1:0]              out_status,
  output logic signed [WORD_WIDTH-1:0] out_data_out,
  output logic [CNT_W-1:0]             out_entry_count,
  output logic                         out_full_flag,
  output logic                         out_empty_flag,
  input  logic                         cfg_we,
  input  logic [CAP_W-1:0]             cfg_wdata
  );

  localparam int RING_CAP = (RING_DEPTH > (2**CNT_W)) ? (2**CNT_W) : RING_DEPTH;
  localparam int NCELL    = RING_CAP - 1;
  localparam logic [CNT_W-1:0] USABLE_MAX = CNT_W'(NCELL);

  logic [CAP_W-1:0]      cap_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [CNT_W-1:0]      usable;
  logic                  full_now;
  logic                  empty_now;
  logic                  accept;
  cq_op_t                op;
  logic [WORD_WIDTH-1:0] head_word;

  logic                  out_valid_r;
  logic [ST_W-1:0]       status_nxt;
  logic [ST_W-1:0]       status_r;
  logic [WORD_WIDTH-1:0] data_nxt;
  logic [WORD_WIDTH-1:0] data_r;
  logic [CNT_W-1:0]      ocount_r;
  logic                  full_r;
  logic                  empty_r;

  assign usable    = (CNT_W'(cap_r) > USABLE_MAX) ? USABLE_MAX : CNT_W'(cap_r);
  assign full_now  = (count_r == usable);
  assign empty_now = (count_r == '0);
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    op         = '0;
    op.idx     = count_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    data_nxt   = '0;
    case (in_req_type)
      REQ_ENQ: begin
        if (full_now) begin
          status_nxt = ST_FULL;
        end else begin
          op.enq    = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_DEQ: begin
        if (empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          op.deq    = accept;
          count_nxt = count_r - CNT_W'(1);
          data_nxt  = head_word;
        end
      end
      REQ_PEEK: begin
        if (empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_nxt = head_word;
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  cq_chain #(.NCELL(NCELL), .WORD_WIDTH(WORD_WIDTH)) u_chain (
    .clk       (clk),
    .op        (op),
    .data_in   (in_data_in),
    .head_word (head_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r   <= cfg_wdata;
        count_r <= '0;
      end else if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      ocount_r <= count_nxt;
      full_r   <= (count_nxt == usable);
      empty_r  <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data_out    = data_r;
  assign out_entry_count = ocount_r;
  assign out_full_flag   = full_r;
  assign out_empty_flag  = empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= usable)
    else $error("entry count beyond usable depth");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we && (in_req_type == REQ_ENQ) && !full_now
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("enqueue did not advance count");

  a_deq_data: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req_type == REQ_DEQ) && !empty_now
    |=> out_valid && (out_data_out == $past(head_word)))
    else $error("dequeue returned wrong head word");

  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_nxt != ST_OK) |=> out_data_out == '0)
    else $error("refused request returned data");

  a_both_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_flag && out_empty_flag |-> out_entry_count == '0)
    else $error("full and empty with stored entries");

endmodule
